/* sv/hsfd_pkg.sv */
// Shared types, constants and the CRC-8 byte update for the sensor frame decoder.
`timescale 1ns / 1ps

package hsfd_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Byte positions within a response frame; POS_IDLE means waiting for a frame start
  localparam logic [2:0] POS_T_MSB = 3'd0;
  localparam logic [2:0] POS_T_LSB = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_MSB = 3'd3;
  localparam logic [2:0] POS_H_LSB = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;
  localparam logic [2:0] POS_IDLE  = 3'd6;

  // Scale factors: full scale 175.00 degC and 100.00 %RH in hundredths
  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [13:0] RH_SPAN     = 14'd10000;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam logic [16:0] RAW_FULL    = 17'd65535;

  typedef struct packed {
    logic signed [14:0] temp_centi;
    logic [13:0]        rh_centi;
  } reading_t;

  // One CRC-8 byte update, MSB first, no reflection
  function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* sv/hsfd_scale.sv */
// Converts raw temperature and humidity words to hundredths of a degree and percent.
`timescale 1ns / 1ps

module hsfd_scale
  import hsfd_pkg::*;
(
  input  logic [15:0] temp_raw,
  input  logic [15:0] hum_raw,
  output reading_t    reading
);

  logic [30:0] temp_prod;
  logic [14:0] temp_q0;
  logic [16:0] temp_rem;
  logic [14:0] temp_q;
  logic [29:0] rh_prod;
  logic [13:0] rh_q0;
  logic [16:0] rh_rem;
  logic [13:0] rh_q;

  // Divide by 65535: take the quotient by 65536, then correct by one where the
  // remainder, low half plus quotient, reaches 65535 (it stays below twice that).
  always_comb begin
    temp_prod = 31'(TEMP_SPAN) * 31'(temp_raw);
    temp_q0   = temp_prod[30:16];
    temp_rem  = 17'(temp_prod[15:0]) + 17'(temp_q0);
    temp_q    = temp_q0 + 15'(temp_rem >= RAW_FULL);

    rh_prod   = 30'(RH_SPAN) * 30'(hum_raw);
    rh_q0     = rh_prod[29:16];
    rh_rem    = 17'(rh_prod[15:0]) + 17'(rh_q0);
    rh_q      = rh_q0 + 14'(rh_rem >= RAW_FULL);

    reading.temp_centi = $signed(temp_q - TEMP_OFFSET);
    reading.rh_centi   = rh_q;
  end

endmodule

/* sv/humidity_sensor_frame_decoder.sv */
// Top level of the sensor response frame decoder: byte register, frame state and result register.
`timescale 1ns / 1ps

// Takes the six response bytes of a temperature and humidity sensor (temperature
// MSB, LSB, CRC, humidity MSB, LSB, CRC), one byte per input transfer, with
// in_tuser high on the first byte of a frame. A high in_tuser always restarts the
// frame, even part-way through one; bytes that arrive after the sixth and before
// the next frame start are dropped. Each word is checked with CRC-8 (poly 0x31,
// init 0xFF), restarted per word. After the sixth byte one result transfer carries
// the temperature in hundredths of a degree (signed), humidity in hundredths of a
// percent, both CRC flags and reading_valid (both CRCs good). Results go out even
// when a CRC fails. Throughput is one byte per clock: each byte passes an input
// register and then a single pass of CRC update and conversion logic (one constant
// multiplier per reading and a one-step divide-by-65535 correction) into the result
// register, which is loaded as the sixth byte leaves the input register. The input
// stage keeps taking bytes while a result waits; it stalls only when a frame-ending
// byte meets a result register that has not been taken.
module humidity_sensor_frame_decoder
  import hsfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [14:0] temp_centi, [28:15] rh_centi, [31:29] zero
  output logic [2:0]  out_tuser   // [0] temp_crc_ok, [1] rh_crc_ok, [2] reading_valid
);

  // Input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_start_r;

  // Frame state
  logic [2:0]  byte_index_r, byte_index_nxt;
  logic [7:0]  crc_acc_r, crc_acc_nxt;
  logic [7:0]  high_byte_r, high_byte_nxt;
  logic [15:0] temp_raw_r, temp_raw_nxt;
  logic        temp_ok_r, temp_ok_nxt;
  logic [7:0]  hum_high_r, hum_high_nxt;

  // Result register
  logic        out_valid_r, out_valid_nxt;
  reading_t    out_reading_r;
  logic [2:0]  out_flags_r;

  logic        s1_active;
  logic [2:0]  s1_pos;
  logic        s1_res;
  logic        s1_go;
  logic        out_free;
  logic [7:0]  crc_upd;
  logic        rh_ok;
  reading_t    reading;

  hsfd_scale u_scale (
    .temp_raw (temp_raw_r),
    .hum_raw  ({hum_high_r, high_byte_r}),
    .reading  (reading)
  );

  always_comb begin
    s1_active = s1_start_r || (byte_index_r < POS_IDLE);
    s1_pos    = s1_start_r ? POS_T_MSB : byte_index_r;
    s1_res    = s1_valid_r && s1_active && (s1_pos == POS_H_CRC);
    out_free  = !out_valid_r || out_tready;
    // Advance the held byte unless it ends a frame while the result slot is full and not being taken
    s1_go     = s1_valid_r && (!s1_res || out_free);
    in_tready = !s1_valid_r || s1_go;
    crc_upd   = crc8_byte((s1_pos == POS_T_MSB || s1_pos == POS_H_MSB) ? CRC_INIT : crc_acc_r,
                          s1_byte_r);
    rh_ok     = (crc_acc_r == s1_byte_r);
  end

  always_comb begin
    s1_valid_nxt   = in_tready ? in_tvalid : s1_valid_r;
    byte_index_nxt = byte_index_r;
    crc_acc_nxt    = crc_acc_r;
    high_byte_nxt  = high_byte_r;
    temp_raw_nxt   = temp_raw_r;
    temp_ok_nxt    = temp_ok_r;
    hum_high_nxt   = hum_high_r;
    if (s1_go && s1_active) begin
      byte_index_nxt = s1_pos + 3'd1;
      unique case (s1_pos)
        POS_T_MSB: begin
          crc_acc_nxt   = crc_upd;
          high_byte_nxt = s1_byte_r;
        end
        POS_T_LSB: begin
          crc_acc_nxt  = crc_upd;
          temp_raw_nxt = {high_byte_r, s1_byte_r};
        end
        POS_T_CRC: begin
          temp_ok_nxt = (crc_acc_r == s1_byte_r);
          crc_acc_nxt = CRC_INIT;
        end
        POS_H_MSB: begin
          crc_acc_nxt  = crc_upd;
          hum_high_nxt = s1_byte_r;
        end
        POS_H_LSB: begin
          crc_acc_nxt   = crc_upd;
          high_byte_nxt = s1_byte_r;
        end
        POS_H_CRC: begin
          crc_acc_nxt    = CRC_INIT;
          byte_index_nxt = POS_IDLE;
        end
        default: begin
          byte_index_nxt = POS_IDLE;
        end
      endcase
    end
    // Load a fresh result, or drop the current one once it is taken
    if (s1_go && s1_res) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      byte_index_r <= POS_IDLE;
      crc_acc_r    <= CRC_INIT;
      high_byte_r  <= 8'd0;
      temp_raw_r   <= 16'd0;
      temp_ok_r    <= 1'b0;
      hum_high_r   <= 8'd0;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      byte_index_r <= byte_index_nxt;
      crc_acc_r    <= crc_acc_nxt;
      high_byte_r  <= high_byte_nxt;
      temp_raw_r   <= temp_raw_nxt;
      temp_ok_r    <= temp_ok_nxt;
      hum_high_r   <= hum_high_nxt;
    end
  end

  // Payload registers: hold the byte until it advances, load the result on frame end
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r  <= in_tdata;
      s1_start_r <= in_tuser;
    end
    if (s1_go && s1_res) begin
      out_reading_r <= reading;
      out_flags_r   <= {temp_ok_r & rh_ok, rh_ok, temp_ok_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_reading_r.rh_centi, out_reading_r.temp_centi};
  assign out_tuser  = out_flags_r;

  // A frame-ending byte that fires a result returns the decoder to idle
  a_result_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_res) |=> (out_valid_r && byte_index_r == POS_IDLE))
    else $error("result produced without returning to idle");

  // Back-pressure on the input only comes from a byte held in the input register
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && s1_res && out_valid_r && !out_tready))
    else $error("input stalled without a blocked frame-ending byte");

  // A blocked frame-ending byte stays in the input register
  a_blocked_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_res && !out_free) |=> (s1_valid_r && $stable(s1_byte_r)))
    else $error("blocked frame-ending byte lost");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_index_r <= POS_IDLE)
    else $error("byte index out of range");

endmodule

/* tb/humidity_sensor_frame_decoder_tb.sv */
// Self-checking testbench for the sensor response frame decoder: CRC and conversion checks.
`timescale 1ns / 1ps

module humidity_sensor_frame_decoder_tb;
  import hsfd_pkg::*;

  // Idle cycles with no transfer on either side before the run is abandoned
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  // Length of the receiver hold-off used to back the decoder up
  localparam int unsigned HOLD_CYCLES    = 400;
  // Cycles to wait after the last result for anything stray
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned PHASE_ITEMS    = 430;

  typedef struct packed {
    logic       start;
    logic [7:0] data;
  } rx_item_t;

  typedef struct packed {
    logic [14:0] temp;
    logic [13:0] rh;
    logic        t_ok;
    logic        h_ok;
    logic        valid;
  } reading_exp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] rx_byte
  logic        in_tuser = 1'b0;    // [0] frame_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // [14:0] temp_centi, [28:15] rh_centi, [31:29] zero
  logic [2:0]  out_tuser;          // [0] temp_crc_ok, [1] rh_crc_ok, [2] reading_valid

  rx_item_t     bytes_to_send[$];
  reading_exp_t readings_due[$];

  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_token = 0;
  int unsigned hold_seen;
  int unsigned hold_cnt;
  int unsigned idle_cycles = 0;
  int unsigned mismatch_count = 0;

  // Predictor state, a private copy of the decoder's frame registers
  logic [2:0]  dec_pos;
  logic [7:0]  dec_crc;
  logic [7:0]  dec_hi_byte;
  logic [15:0] dec_t_word;
  logic        dec_t_good;
  logic [7:0]  dec_h_msb;

  rx_item_t     next_item;
  reading_exp_t want;

  humidity_sensor_frame_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // CRC-8, MSB first, one byte folded in eight shift steps
  function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    r = acc ^ b;
    repeat (8) begin
      if (r[7]) begin
        r = {r[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] word_crc(input logic [15:0] w);
    return crc8_next(crc8_next(CRC_INIT, w[15:8]), w[7:0]);
  endfunction

  // Advance the predicted frame state by one accepted byte; queue a reading on byte six
  task automatic decode_byte(input logic [7:0] b, input logic start);
    logic [2:0]   slot;
    logic [15:0]  h_word;
    logic [63:0]  t_q;
    logic [63:0]  h_q;
    logic [31:0]  t_signed;
    reading_exp_t r;
    if (start) begin
      slot = POS_T_MSB;
    end else if (dec_pos == POS_IDLE) begin
      return;   // drop stray bytes between frames
    end else begin
      slot = dec_pos;
    end
    case (slot)
      POS_T_MSB: begin
        dec_crc     = crc8_next(CRC_INIT, b);
        dec_hi_byte = b;
      end
      POS_T_LSB: begin
        dec_crc    = crc8_next(dec_crc, b);
        dec_t_word = {dec_hi_byte, b};
      end
      POS_T_CRC: begin
        dec_t_good = (dec_crc == b);
        dec_crc    = CRC_INIT;
      end
      POS_H_MSB: begin
        dec_crc   = crc8_next(CRC_INIT, b);
        dec_h_msb = b;
      end
      POS_H_LSB: begin
        dec_crc     = crc8_next(dec_crc, b);
        dec_hi_byte = b;
      end
      default: begin
        h_word   = {dec_h_msb, dec_hi_byte};
        t_q      = (64'd17500 * dec_t_word) / 64'd65535;
        h_q      = (64'd10000 * h_word) / 64'd65535;
        t_signed = t_q[31:0] - 32'd4500;
        r.temp   = t_signed[14:0];
        r.rh     = h_q[13:0];
        r.t_ok   = dec_t_good;
        r.h_ok   = (dec_crc == b);
        r.valid  = dec_t_good & (dec_crc == b);
        readings_due.push_back(r);
        dec_crc  = CRC_INIT;
      end
    endcase
    dec_pos = (slot == POS_H_CRC) ? POS_IDLE : slot + 3'd1;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // Driver: hold the offered byte until its transfer, then fetch the next one or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid   <= 1'b0;
      in_tdata    <= 8'h00;
      in_tuser    <= 1'b0;
      dec_pos     = POS_IDLE;
      dec_crc     = CRC_INIT;
      dec_hi_byte = 8'h00;
      dec_t_word  = 16'h0000;
      dec_t_good  = 1'b0;
      dec_h_msb   = 8'h00;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_byte(in_tdata, in_tuser);
      end
      if (!in_tvalid || in_tready) begin
        if (bytes_to_send.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          next_item = bytes_to_send.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= next_item.data;
          in_tuser  <= next_item.start;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare every result transfer with the oldest predicted reading.
  // A new hold token starts a long hold-off, counted down here.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_cnt   <= 0;
      hold_seen  <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (readings_due.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual tdata %0h tuser %0h",
                   $time, out_tdata, out_tuser);
          mismatch_count++;
        end else begin
          want = readings_due.pop_front();
          check_field("temp_centi", {17'd0, want.temp}, {17'd0, out_tdata[14:0]});
          check_field("rh_centi", {18'd0, want.rh}, {18'd0, out_tdata[28:15]});
          check_field("tdata padding", 32'd0, {29'd0, out_tdata[31:29]});
          check_field("temp_crc_ok", {31'd0, want.t_ok}, {31'd0, out_tuser[0]});
          check_field("rh_crc_ok", {31'd0, want.h_ok}, {31'd0, out_tuser[1]});
          check_field("reading_valid", {31'd0, want.valid}, {31'd0, out_tuser[2]});
        end
      end
      if (hold_seen != hold_token) begin
        hold_seen  <= hold_token;
        hold_cnt   <= HOLD_CYCLES;
        out_tready <= 1'b0;
      end else if (hold_cnt != 0) begin
        hold_cnt   <= hold_cnt - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // Watchdog: abandon the run if nothing transfers for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("humidity_sensor_frame_decoder_tb: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic start);
    rx_item_t it;
    it.data  = b;
    it.start = start;
    bytes_to_send.push_back(it);
  endtask

  // Queue a full six-byte frame; a non-zero flip mask corrupts that word's CRC byte
  task automatic queue_frame(input logic [15:0] t_word, input logic [15:0] h_word,
                             input logic [7:0] t_flip, input logic [7:0] h_flip);
    queue_byte(t_word[15:8], 1'b1);
    queue_byte(t_word[7:0], 1'b0);
    queue_byte(word_crc(t_word) ^ t_flip, 1'b0);
    queue_byte(h_word[15:8], 1'b0);
    queue_byte(h_word[7:0], 1'b0);
    queue_byte(word_crc(h_word) ^ h_flip, 1'b0);
  endtask

  // Bias raw words towards the ends of the scale
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [7:0] pick_flip();
    return ($urandom_range(0, 5) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
  endfunction

  // Mostly whole frames with random content, some with a corrupted CRC; the rest broken frames and line noise
  task automatic queue_random_traffic(input int unsigned n_items);
    int unsigned counted;
    int unsigned kind;
    int unsigned len;
    counted = 0;
    while (counted < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        queue_frame(pick_word(), pick_word(), pick_flip(), pick_flip());
        counted += 6;
      end else if (kind < 88) begin
        len = $urandom_range(1, 5);
        queue_byte(8'($urandom_range(0, 255)), 1'b1);
        repeat (len) queue_byte(8'($urandom_range(0, 255)), 1'b0);
        counted += len + 1;
      end else begin
        repeat ($urandom_range(1, 3)) begin
          queue_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 5) == 0));
        end
      end
    end
  endtask

  // Wait until the queue is sent and every predicted reading has arrived
  task automatic drain();
    while (bytes_to_send.size() != 0 || in_tvalid) @(negedge clk);
    while (readings_due.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: stray byte after reset, scale ends, each CRC failing alone,
    // idle bytes after a frame and a restart part-way through a frame
    queue_byte(8'hA5, 1'b0);
    queue_frame(16'h0000, 16'h0000, 8'h00, 8'h00);
    queue_byte(8'h00, 1'b0);
    queue_frame(16'hFFFF, 16'hFFFF, 8'h80, 8'h00);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h12, 1'b1);
    queue_byte(8'h34, 1'b0);
    queue_byte(8'h56, 1'b0);
    queue_frame(16'h6666, 16'h8000, 8'h00, 8'h01);
    drain();

    // No idling on either side
    queue_random_traffic(PHASE_ITEMS);
    drain();

    // Back the decoder up: the receiver holds off while frames keep coming
    hold_token = hold_token + 1;
    repeat (12) queue_frame(pick_word(), pick_word(), pick_flip(), 8'h00);
    drain();

    // Sender mostly idle
    tx_idle_pct = 81;
    queue_random_traffic(PHASE_ITEMS);
    drain();

    // Receiver mostly stalling
    tx_idle_pct  = 0;
    rx_stall_pct = 81;
    queue_random_traffic(PHASE_ITEMS);
    drain();

    // Both sides idling now and then
    tx_idle_pct  = 24;
    rx_stall_pct = 24;
    queue_random_traffic(PHASE_ITEMS);
    drain();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && readings_due.size() == 0) begin
      $display("humidity_sensor_frame_decoder_tb: PASS");
    end else begin
      $display("humidity_sensor_frame_decoder_tb: FAIL");
    end
    $finish;
  end

endmodule
